[hw/rtl/cbsma_pkg.sv]
// Package of the complex BCD sign-magnitude accumulator: codes, types and defaults.
`default_nettype none
package cbsma_pkg;

	// Width of every magnitude field on the ports.
	localparam int FIELD_W = 64;
	// Default number of BCD digits in each part.
	localparam int DIGITS_DEF = 16;
	// Largest value that a BCD nibble may hold.
	localparam logic [3:0] BCD_MAX = 4'd9;
	localparam logic [4:0] BCD_BASE = 5'd10;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SETUP,
		SEQ_RUN,
		SEQ_DONE
	} seq_state_t;

	// Strobes from the sequencer to the datapath.
	typedef struct packed {
		logic in_ready;
		logic lane_start;
		logic lane_step;
		logic commit;
	} seq_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/cbsma_if.sv]
// Request channels of the accumulator: operand requests in, result requests out.
`default_nettype none
interface cbsma_in_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        operation;
	logic                              real_sign;
	logic [cbsma_pkg::FIELD_W-1:0]     real_digits;
	logic                              imag_sign;
	logic [cbsma_pkg::FIELD_W-1:0]     imag_digits;

	modport source (
		output valid, operation, real_sign, real_digits, imag_sign, imag_digits,
		input  ready
	);
	modport sink (
		input  valid, operation, real_sign, real_digits, imag_sign, imag_digits,
		output ready
	);
endinterface

interface cbsma_out_if;
	logic                              valid;
	logic                              ready;
	logic                              sum_real_sign;
	logic [cbsma_pkg::FIELD_W-1:0]     sum_real_digits;
	logic                              sum_imag_sign;
	logic [cbsma_pkg::FIELD_W-1:0]     sum_imag_digits;
	logic                              bad_digit;

	modport source (
		output valid, sum_real_sign, sum_real_digits, sum_imag_sign, sum_imag_digits,
		       bad_digit,
		input  ready
	);
	modport sink (
		input  valid, sum_real_sign, sum_real_digits, sum_imag_sign, sum_imag_digits,
		       bad_digit,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/cbsma_digit_unit.sv]
// One-digit BCD adder and subtractor with carry or borrow.
`default_nettype none
module cbsma_digit_unit (
	input  wire logic [3:0] a,
	input  wire logic [3:0] b,
	input  wire logic       cin,
	input  wire logic       sub,
	output logic      [3:0] digit,
	output logic            cout
);

	logic [4:0] sum;
	logic [4:0] sub_rhs;
	logic [4:0] diff;

	always_comb begin
		sum     = {1'b0, a} + {1'b0, b} + {4'd0, cin};
		sub_rhs = {1'b0, b} + {4'd0, cin};
		diff    = 5'd0;
		digit   = 4'd0;
		cout    = 1'b0;
		if (sub) begin
			if ({1'b0, a} >= sub_rhs) begin
				diff = {1'b0, a} - sub_rhs;
				cout = 1'b0;
			end else begin
				diff = {1'b0, a} + cbsma_pkg::BCD_BASE - sub_rhs;
				cout = 1'b1;
			end
			digit = diff[3:0];
		end else begin
			if (sum >= cbsma_pkg::BCD_BASE) begin
				digit = 4'(sum - cbsma_pkg::BCD_BASE);
				cout  = 1'b1;
			end else begin
				digit = sum[3:0];
				cout  = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/cbsma_part_lane.sv]
// Digit-serial sign-magnitude adder for one part of the complex value.
`default_nettype none
module cbsma_part_lane #(
	parameter int DIGITS = cbsma_pkg::DIGITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  start,
	input  wire logic                  step,
	input  wire logic                  acc_sign,
	input  wire logic [4*DIGITS-1:0]   acc_mag,
	input  wire logic                  opr_sign,
	input  wire logic [4*DIGITS-1:0]   opr_mag,
	output logic                       res_sign,
	output logic      [4*DIGITS-1:0]   res_mag
);

	localparam int MAG_W = 4 * DIGITS;

	logic [MAG_W-1:0] a_q;
	logic [MAG_W-1:0] b_q;
	logic [MAG_W-1:0] r_q;
	logic             c_q;
	logic             sub_q;
	logic             sign_q;
	logic [3:0]       digit;
	logic             cout;

	cbsma_digit_unit u_digit (
		.a     (a_q[3:0]),
		.b     (b_q[3:0]),
		.cin   (c_q),
		.sub   (sub_q),
		.digit (digit),
		.cout  (cout)
	);

	// On start the operands are ordered so that a subtraction never goes negative.
	// Equal magnitudes with unequal signs run as zero plus zero, giving plus zero.
	always_ff @(posedge clk) begin
		if (start) begin
			c_q <= 1'b0;
			if (acc_sign == opr_sign) begin
				a_q    <= acc_mag;
				b_q    <= opr_mag;
				sub_q  <= 1'b0;
				sign_q <= acc_sign;
			end else if (acc_mag == opr_mag) begin
				a_q    <= '0;
				b_q    <= '0;
				sub_q  <= 1'b0;
				sign_q <= 1'b0;
			end else if (acc_mag > opr_mag) begin
				a_q    <= acc_mag;
				b_q    <= opr_mag;
				sub_q  <= 1'b1;
				sign_q <= acc_sign;
			end else begin
				a_q    <= opr_mag;
				b_q    <= acc_mag;
				sub_q  <= 1'b1;
				sign_q <= opr_sign;
			end
		end else if (step) begin
			a_q <= a_q >> 4;
			b_q <= b_q >> 4;
			r_q <= (r_q >> 4) | (MAG_W'(digit) << (MAG_W - 4));
			c_q <= cout;
		end
	end

	assign res_sign = sign_q;
	assign res_mag  = r_q;

endmodule
`default_nettype wire

[hw/rtl/cbsma_ctrl.sv]
// Sequencer: accepts a request, runs the digit passes and commits the result.
`default_nettype none
module cbsma_ctrl #(
	parameter int DIGITS = cbsma_pkg::DIGITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  need_lanes,
	input  wire logic                  out_free,
	output cbsma_pkg::seq_ctrl_t       ctrl
);

	localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

	cbsma_pkg::seq_state_t state_q;
	cbsma_pkg::seq_state_t state_d;
	logic [CNT_W-1:0]      cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbsma_pkg::SEQ_IDLE: begin
				if (in_valid) begin
					state_d = need_lanes ? cbsma_pkg::SEQ_SETUP : cbsma_pkg::SEQ_DONE;
				end
			end
			cbsma_pkg::SEQ_SETUP: state_d = cbsma_pkg::SEQ_RUN;
			cbsma_pkg::SEQ_RUN: begin
				if (cnt_q == CNT_LAST) begin
					state_d = cbsma_pkg::SEQ_DONE;
				end
			end
			cbsma_pkg::SEQ_DONE: begin
				if (out_free) begin
					state_d = cbsma_pkg::SEQ_IDLE;
				end
			end
			default: state_d = cbsma_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			cbsma_pkg::SEQ_IDLE:  ctrl.in_ready   = 1'b1;
			cbsma_pkg::SEQ_SETUP: ctrl.lane_start = 1'b1;
			cbsma_pkg::SEQ_RUN:   ctrl.lane_step  = 1'b1;
			cbsma_pkg::SEQ_DONE:  ctrl.commit     = out_free;
			default:              ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbsma_pkg::SEQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cbsma_pkg::SEQ_RUN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/complex_bcd_sign_magnitude_accumulator_top.sv]
// Top level of the complex BCD sign-magnitude accumulator.
//
//  channel   | direction | fields
//  ----------+-----------+----------------------------------------------------------
//  operand   | in        | operation, real_sign, real_digits, imag_sign, imag_digits
//  result    | out       | sum_real_sign, sum_real_digits, sum_imag_sign,
//            |           | sum_imag_digits, bad_digit
//
// An add or subtract request is accepted, has its magnitudes ordered, runs the digit-serial
// pass of the two part lanes side by side and is then committed. A load, a rejected
// operand or an unused code goes from acceptance straight to the commit.
// Reset clears the accumulator to plus zero. A new request is taken while the
// previous result still waits; the commit waits until the result register is free.
`default_nettype none
module complex_bcd_sign_magnitude_accumulator_top #(
	parameter int DIGITS = cbsma_pkg::DIGITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cbsma_in_if.sink    operand,
	cbsma_out_if.source result
);

	localparam int MAG_W = 4 * DIGITS;

	cbsma_pkg::seq_ctrl_t ctrl;
	cbsma_pkg::op_t       op_in;
	cbsma_pkg::op_t       op_q;
	logic                 digit_err;
	logic                 bad_in;
	logic                 need_lanes;
	logic                 in_fire;
	logic                 out_free;
	logic                 bad_q;
	logic                 opr_re_sign_q;
	logic [MAG_W-1:0]     opr_re_mag_q;
	logic                 opr_im_sign_q;
	logic [MAG_W-1:0]     opr_im_mag_q;
	logic                 acc_re_sign_q;
	logic [MAG_W-1:0]     acc_re_mag_q;
	logic                 acc_im_sign_q;
	logic [MAG_W-1:0]     acc_im_mag_q;
	logic                 lane_re_sign;
	logic [MAG_W-1:0]     lane_re_mag;
	logic                 lane_im_sign;
	logic [MAG_W-1:0]     lane_im_mag;
	logic                 out_valid_q;
	logic                 out_bad_q;

	assign op_in    = cbsma_pkg::op_t'(operand.operation);
	assign in_fire  = operand.valid && ctrl.in_ready;
	assign out_free = !out_valid_q || result.ready;

	// Nibbles above the digit field are neither checked nor used.
	// The unused operation code is never flagged, whatever its digits hold.
	always_comb begin
		digit_err = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (operand.real_digits[4*i +: 4] > cbsma_pkg::BCD_MAX ||
			    operand.imag_digits[4*i +: 4] > cbsma_pkg::BCD_MAX) begin
				digit_err = 1'b1;
			end
		end
		case (op_in)
			cbsma_pkg::OP_LOAD: begin
				bad_in     = digit_err;
				need_lanes = 1'b0;
			end
			cbsma_pkg::OP_ADD, cbsma_pkg::OP_SUB: begin
				bad_in     = digit_err;
				need_lanes = !digit_err;
			end
			default: begin
				bad_in     = 1'b0;
				need_lanes = 1'b0;
			end
		endcase
	end

	cbsma_ctrl #(.DIGITS(DIGITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (operand.valid),
		.need_lanes (need_lanes),
		.out_free   (out_free),
		.ctrl       (ctrl)
	);

	// Operand capture; a subtraction flips both signs here.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q          <= op_in;
			bad_q         <= bad_in;
			opr_re_sign_q <= operand.real_sign ^ (op_in == cbsma_pkg::OP_SUB);
			opr_re_mag_q  <= operand.real_digits[MAG_W-1:0];
			opr_im_sign_q <= operand.imag_sign ^ (op_in == cbsma_pkg::OP_SUB);
			opr_im_mag_q  <= operand.imag_digits[MAG_W-1:0];
		end
	end

	cbsma_part_lane #(.DIGITS(DIGITS)) u_lane_re (
		.clk      (clk),
		.start    (ctrl.lane_start),
		.step     (ctrl.lane_step),
		.acc_sign (acc_re_sign_q),
		.acc_mag  (acc_re_mag_q),
		.opr_sign (opr_re_sign_q),
		.opr_mag  (opr_re_mag_q),
		.res_sign (lane_re_sign),
		.res_mag  (lane_re_mag)
	);

	cbsma_part_lane #(.DIGITS(DIGITS)) u_lane_im (
		.clk      (clk),
		.start    (ctrl.lane_start),
		.step     (ctrl.lane_step),
		.acc_sign (acc_im_sign_q),
		.acc_mag  (acc_im_mag_q),
		.opr_sign (opr_im_sign_q),
		.opr_mag  (opr_im_mag_q),
		.res_sign (lane_im_sign),
		.res_mag  (lane_im_mag)
	);

	// The accumulator changes only at a commit, which needs a free result register,
	// so it doubles as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_sign_q <= 1'b0;
			acc_re_mag_q  <= '0;
			acc_im_sign_q <= 1'b0;
			acc_im_mag_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.commit && !bad_q) begin
				case (op_q)
					cbsma_pkg::OP_LOAD: begin
						acc_re_sign_q <= opr_re_sign_q;
						acc_re_mag_q  <= opr_re_mag_q;
						acc_im_sign_q <= opr_im_sign_q;
						acc_im_mag_q  <= opr_im_mag_q;
					end
					cbsma_pkg::OP_ADD, cbsma_pkg::OP_SUB: begin
						acc_re_sign_q <= lane_re_sign;
						acc_re_mag_q  <= lane_re_mag;
						acc_im_sign_q <= lane_im_sign;
						acc_im_mag_q  <= lane_im_mag;
					end
					default: begin
						acc_re_sign_q <= acc_re_sign_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_bad_q <= bad_q;
		end
	end

	assign operand.ready          = ctrl.in_ready;
	assign result.valid           = out_valid_q;
	assign result.sum_real_sign   = acc_re_sign_q;
	assign result.sum_real_digits = cbsma_pkg::FIELD_W'(acc_re_mag_q);
	assign result.sum_imag_sign   = acc_im_sign_q;
	assign result.sum_imag_digits = cbsma_pkg::FIELD_W'(acc_im_mag_q);
	assign result.bad_digit       = out_bad_q;

endmodule
`default_nettype wire

[bench/cbsma_checker.sv]
// Checker of the accumulator: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps
module cbsma_checker #(
	parameter int DIGITS = cbsma_pkg::DIGITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	cbsma_in_if   operand,
	cbsma_out_if  result,
	output int    errors,
	output int    pending,
	output int    compared,
	output int    flagged
);

	typedef struct packed {
		logic                          real_sign;
		logic [cbsma_pkg::FIELD_W-1:0] real_mag;
		logic                          imag_sign;
		logic [cbsma_pkg::FIELD_W-1:0] imag_mag;
		logic                          bad;
	} acc_view_t;

	logic                          acc_real_sign;
	logic [cbsma_pkg::FIELD_W-1:0] acc_real_mag;
	logic                          acc_imag_sign;
	logic [cbsma_pkg::FIELD_W-1:0] acc_imag_mag;
	acc_view_t                     expected_sums[$];

	// Nibbles at and above DIGITS play no part and count as zero.
	function automatic logic [cbsma_pkg::FIELD_W-1:0] trim_digits(
			input logic [cbsma_pkg::FIELD_W-1:0] v);
		for (int i = DIGITS; i < cbsma_pkg::FIELD_W / 4; i++)
			v[4*i +: 4] = '0;
		return v;
	endfunction

	function automatic logic digits_ok(input logic [cbsma_pkg::FIELD_W-1:0] v);
		for (int i = 0; i < DIGITS; i++)
			if (v[4*i +: 4] > cbsma_pkg::BCD_MAX)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [cbsma_pkg::FIELD_W-1:0] bcd_sum(
			input logic [cbsma_pkg::FIELD_W-1:0] a, b);
		logic [cbsma_pkg::FIELD_W-1:0] r;
		logic [4:0]                    s;
		logic                          carry;
		r = '0;
		carry = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			s = a[4*i +: 4] + b[4*i +: 4] + carry;
			carry = (s >= cbsma_pkg::BCD_BASE);
			if (carry)
				s = s - cbsma_pkg::BCD_BASE;
			r[4*i +: 4] = s[3:0];
		end
		return r;
	endfunction

	// Requires a >= b.
	function automatic logic [cbsma_pkg::FIELD_W-1:0] bcd_diff(
			input logic [cbsma_pkg::FIELD_W-1:0] a, b);
		logic [cbsma_pkg::FIELD_W-1:0] r;
		logic [4:0]                    da;
		logic [4:0]                    db;
		logic                          borrow;
		r = '0;
		borrow = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			da = {1'b0, a[4*i +: 4]};
			db = b[4*i +: 4] + borrow;
			borrow = (da < db);
			if (borrow)
				da = da + cbsma_pkg::BCD_BASE;
			r[4*i +: 4] = 4'(da - db);
		end
		return r;
	endfunction

	function automatic void add_part(inout logic sign,
			inout logic [cbsma_pkg::FIELD_W-1:0] mag,
			input logic osign, input logic [cbsma_pkg::FIELD_W-1:0] omag);
		if (sign == osign) begin
			mag = bcd_sum(mag, omag);
		end else if (mag == omag) begin
			sign = 1'b0;
			mag = '0;
		end else if (mag > omag) begin
			mag = bcd_diff(mag, omag);
		end else begin
			mag = bcd_diff(omag, mag);
			sign = osign;
		end
	endfunction

	function automatic acc_view_t accumulate_request(input logic [1:0] op,
			input logic rs, input logic [cbsma_pkg::FIELD_W-1:0] rd,
			input logic ims, input logic [cbsma_pkg::FIELD_W-1:0] imd);
		acc_view_t v;
		logic      bad;
		rd = trim_digits(rd);
		imd = trim_digits(imd);
		bad = 1'b0;
		if (op == cbsma_pkg::OP_LOAD || op == cbsma_pkg::OP_ADD ||
		    op == cbsma_pkg::OP_SUB) begin
			if (!digits_ok(rd) || !digits_ok(imd)) begin
				bad = 1'b1;
			end else if (op == cbsma_pkg::OP_LOAD) begin
				acc_real_sign = rs;
				acc_real_mag = rd;
				acc_imag_sign = ims;
				acc_imag_mag = imd;
			end else begin
				if (op == cbsma_pkg::OP_SUB) begin
					rs = !rs;
					ims = !ims;
				end
				add_part(acc_real_sign, acc_real_mag, rs, rd);
				add_part(acc_imag_sign, acc_imag_mag, ims, imd);
			end
		end
		v.real_sign = acc_real_sign;
		v.real_mag = acc_real_mag;
		v.imag_sign = acc_imag_sign;
		v.imag_mag = acc_imag_mag;
		v.bad = bad;
		return v;
	endfunction

	task automatic report_mismatch(input string what,
			input logic [cbsma_pkg::FIELD_W-1:0] got,
			input logic [cbsma_pkg::FIELD_W-1:0] want);
		if (errors < 40)
			$display("ERROR at %0t ns: %s is %h, should be %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		acc_view_t want;
		if (!arst_n) begin
			acc_real_sign = 1'b0;
			acc_real_mag = '0;
			acc_imag_sign = 1'b0;
			acc_imag_mag = '0;
			expected_sums.delete();
		end else begin
			// A new request enters the queue before a finished result leaves it.
			if (operand.valid && operand.ready)
				expected_sums.push_back(accumulate_request(operand.operation,
					operand.real_sign, operand.real_digits,
					operand.imag_sign, operand.imag_digits));
			if (result.valid && result.ready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch("result with no request outstanding, real digits",
						result.sum_real_digits, '0);
				end else begin
					want = expected_sums.pop_front();
					compared++;
					if (want.bad)
						flagged++;
					if (result.sum_real_sign !== want.real_sign)
						report_mismatch("sum_real_sign", result.sum_real_sign,
							want.real_sign);
					if (result.sum_real_digits !== want.real_mag)
						report_mismatch("sum_real_digits", result.sum_real_digits,
							want.real_mag);
					if (result.sum_imag_sign !== want.imag_sign)
						report_mismatch("sum_imag_sign", result.sum_imag_sign,
							want.imag_sign);
					if (result.sum_imag_digits !== want.imag_mag)
						report_mismatch("sum_imag_digits", result.sum_imag_digits,
							want.imag_mag);
					if (result.bad_digit !== want.bad)
						report_mismatch("bad_digit", result.bad_digit, want.bad);
				end
			end
		end
		pending = expected_sums.size();
	end
endmodule

[bench/tb_top.sv]
// Testbench top of the accumulator: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int         DIGITS    = cbsma_pkg::DIGITS_DEF;
	localparam int         RANDOM_N  = 430;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [cbsma_pkg::FIELD_W-1:0] ALL_NINES = 64'h9999_9999_9999_9999;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   compared;
	int   flagged;
	int   n_load;
	int   n_add;
	int   n_sub;
	int   n_unused;
	logic tx_burst;

	cbsma_in_if  operand_ch ();
	cbsma_out_if result_ch ();

	complex_bcd_sign_magnitude_accumulator_top #(.DIGITS(DIGITS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch)
	);

	cbsma_checker #(.DIGITS(DIGITS)) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.operand  (operand_ch),
		.result   (result_ch),
		.errors   (errors),
		.pending  (pending),
		.compared (compared),
		.flagged  (flagged)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Random BCD magnitude: mostly a few digits or all of them, now and then all nines.
	function automatic logic [cbsma_pkg::FIELD_W-1:0] rand_bcd();
		logic [cbsma_pkg::FIELD_W-1:0] v;
		int                            len;
		int                            shape;
		v = '0;
		shape = $urandom_range(0, 9);
		if (shape < 4)
			len = $urandom_range(0, 3);
		else if (shape < 7)
			len = DIGITS;
		else
			len = $urandom_range(0, DIGITS);
		for (int i = 0; i < len; i++)
			v[4*i +: 4] = (shape == 9) ? cbsma_pkg::BCD_MAX : 4'($urandom_range(0, 9));
		return v;
	endfunction

	function automatic logic [cbsma_pkg::FIELD_W-1:0] spoil_digit(
			input logic [cbsma_pkg::FIELD_W-1:0] v);
		v[4*$urandom_range(0, DIGITS - 1) +: 4] = 4'($urandom_range(10, 15));
		return v;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic rs,
			input logic [cbsma_pkg::FIELD_W-1:0] rd, input logic ims,
			input logic [cbsma_pkg::FIELD_W-1:0] imd);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			operand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_ch.valid       <= 1'b1;
		operand_ch.operation   <= op;
		operand_ch.real_sign   <= rs;
		operand_ch.real_digits <= rd;
		operand_ch.imag_sign   <= ims;
		operand_ch.imag_digits <= imd;
		do @(posedge clk); while (!operand_ch.ready);
		case (op)
			cbsma_pkg::OP_LOAD: n_load++;
			cbsma_pkg::OP_ADD:  n_add++;
			cbsma_pkg::OP_SUB:  n_sub++;
			default:            n_unused++;
		endcase
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
	endtask

	// Result side: stalls either from the last acceptance or from the moment a result shows.
	initial begin
		int   stall;
		logic rx_burst;
		rx_burst = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				if ($urandom_range(0, 1) == 1)
					while (!result_ch.valid) @(posedge clk);
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
		end
	end

	initial begin
		int                            kind;
		int                            sent;
		logic [1:0]                    op;
		logic [cbsma_pkg::FIELD_W-1:0] rd;
		logic [cbsma_pkg::FIELD_W-1:0] imd;
		logic                          rs;
		logic                          ims;
		tx_burst = 1'b0;
		operand_ch.valid = 1'b0;
		operand_ch.operation = cbsma_pkg::OP_LOAD;
		operand_ch.real_sign = 1'b0;
		operand_ch.real_digits = '0;
		operand_ch.imag_sign = 1'b0;
		operand_ch.imag_digits = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: wrap-around, minus zero, cancellation, sign change, bad operands.
		send_request(cbsma_pkg::OP_ADD, 1'b0, '0, 1'b0, '0);
		send_request(cbsma_pkg::OP_LOAD, 1'b0, ALL_NINES, 1'b1, ALL_NINES);
		send_request(cbsma_pkg::OP_ADD, 1'b0, 64'h1, 1'b1, 64'h1);
		send_request(cbsma_pkg::OP_LOAD, 1'b1, '0, 1'b1, '0);
		send_request(cbsma_pkg::OP_ADD, 1'b1, '0, 1'b1, '0);
		send_request(cbsma_pkg::OP_SUB, 1'b1, '0, 1'b1, '0);
		send_request(cbsma_pkg::OP_LOAD, 1'b0, 64'h123, 1'b1, 64'h456);
		send_request(cbsma_pkg::OP_SUB, 1'b0, 64'h123, 1'b1, 64'h456);
		send_request(cbsma_pkg::OP_LOAD, 1'b0, 64'h5, 1'b0, 64'h5);
		send_request(cbsma_pkg::OP_ADD, 1'b1, 64'h7, 1'b1, 64'h3);
		send_request(cbsma_pkg::OP_SUB, 1'b0, 64'h8, 1'b1, 64'h1);
		send_request(cbsma_pkg::OP_ADD, 1'b0, 64'h1A, 1'b0, 64'h1);
		send_request(cbsma_pkg::OP_SUB, 1'b1, 64'h2, 1'b0, 64'hF000_0000_0000_0000);
		send_request(cbsma_pkg::OP_LOAD, 1'b1, '1, 1'b1, '1);
		send_request(OP_UNUSED, 1'b1, '1, 1'b1, '1);
		send_request(cbsma_pkg::OP_LOAD, 1'b0, ALL_NINES, 1'b0, ALL_NINES);
		send_request(cbsma_pkg::OP_ADD, 1'b0, ALL_NINES, 1'b0, ALL_NINES);
		send_request(cbsma_pkg::OP_LOAD, 1'b0, 64'h1000_0000_0000_0000, 1'b1, 64'h1);
		send_request(cbsma_pkg::OP_SUB, 1'b0, 64'h0999_9999_9999_9999, 1'b1, 64'h1);
		send_request(cbsma_pkg::OP_ADD, 1'b1, 64'h1, 1'b0, 64'h9);
		send_request(OP_UNUSED, 1'b0, '0, 1'b0, '0);

		// Random part; every request sent counts towards the total.
		sent = 0;
		while (sent < RANDOM_N) begin
			kind = $urandom_range(0, 99);
			rs = 1'($urandom);
			ims = 1'($urandom);
			op = ($urandom_range(0, 1) == 1) ? cbsma_pkg::OP_ADD : cbsma_pkg::OP_SUB;
			if (kind < 4) begin
				send_request(OP_UNUSED, rs, {$urandom, $urandom}, ims, {$urandom, $urandom});
				sent++;
			end else if (kind < 7) begin
				op = 2'($urandom_range(0, 2));
				send_request(op, rs, {$urandom, $urandom}, ims, {$urandom, $urandom});
				sent++;
			end else if (kind < 11) begin
				op = 2'($urandom_range(0, 2));
				rd = rand_bcd();
				imd = rand_bcd();
				case ($urandom_range(0, 2))
					0: rd = spoil_digit(rd);
					1: imd = spoil_digit(imd);
					default: begin
						rd = spoil_digit(rd);
						imd = spoil_digit(imd);
					end
				endcase
				send_request(op, rs, rd, ims, imd);
				sent++;
			end else if (kind < 25) begin
				send_request(cbsma_pkg::OP_LOAD, rs, rand_bcd(), ims, rand_bcd());
				sent++;
			end else if (kind < 35) begin
				// Load a value, then take the same magnitudes away so that both parts cancel.
				rd = rand_bcd();
				imd = rand_bcd();
				send_request(cbsma_pkg::OP_LOAD, rs, rd, ims, imd);
				if (op == cbsma_pkg::OP_ADD)
					send_request(op, !rs, rd, !ims, imd);
				else
					send_request(op, rs, rd, ims, imd);
				sent += 2;
			end else begin
				send_request(op, rs, rand_bcd(), ims, rand_bcd());
				sent++;
			end
		end
		operand_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DIGITS + 8) @(posedge clk);
		$display("Summary: %0d requests: %0d loads, %0d adds, %0d subtracts, %0d unused.",
			n_load + n_add + n_sub + n_unused, n_load, n_add, n_sub, n_unused);
		$display("Summary: %0d results compared, %0d of them with bad digits flagged.",
			compared, flagged);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
